// ===== hdl/evr_pkg.sv =====
// ----------------------------------------------------------------------------
// evr_pkg
// Shared widths, constants, types and the arctangent table of the
// Euler-angle vector rotation core.
// ----------------------------------------------------------------------------
`default_nettype none

package evr_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;

    // coordinate width inside the core: two guard bits over the port width
    localparam int XW     = COORD_WIDTH + 2;
    // sine / cosine width, Q1.15
    localparam int TW     = 16;
    // CORDIC datapath width
    localparam int CDW    = 34;
    localparam int STEPS  = 16;
    localparam int STEP_W = 4;
    // product and sum widths of the axis cells
    localparam int PW     = XW + TW;
    localparam int SW     = PW + 2;
    localparam int FRAC   = 15;

    localparam logic signed [CDW-1:0] CORDIC_X0    = CDW'(64'sh26DD3B6A);
    localparam logic signed [CDW-1:0] QUARTER_TURN = CDW'(64'sh40000000);
    localparam logic signed [CDW-1:0] HALF_TURN    = CDW'(64'sh80000000);
    localparam logic signed [CDW-1:0] TRIG_HALF    = CDW'(64'sh4000);
    localparam logic signed [SW-1:0]  SUM_HALF     = SW'(64'sh4000);
    localparam logic signed [CDW-1:0] TRIG_MAX     = CDW'(64'sh7FFF);
    localparam logic signed [CDW-1:0] TRIG_MIN     = -CDW'(64'sh7FFF);

    localparam logic signed [XW-1:0] COORD_MAX = {3'b000, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] COORD_MIN = {3'b111, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        AXIS_ROLL  = 2'd0,
        AXIS_PITCH = 2'd1,
        AXIS_YAW   = 2'd2
    } axis_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [CDW-1:0] x;
        logic signed [CDW-1:0] y;
        logic signed [CDW-1:0] z;
        logic                  flip;
    } cordic_t;

    // angle order: 0 roll, 1 pitch, 2 yaw
    typedef struct packed {
        vec_t          vec;
        cordic_t [2:0] ang;
    } cord_item_t;

    typedef struct packed {
        logic signed [TW-1:0] sin_v;
        logic signed [TW-1:0] cos_v;
    } trig_t;

    typedef struct packed {
        vec_t        vec;
        trig_t [2:0] trig;
    } rot_item_t;

    typedef struct packed {
        logic signed [PW-1:0] ca;
        logic signed [PW-1:0] sb;
        logic signed [PW-1:0] sa;
        logic signed [PW-1:0] cb;
    } prod_t;

    function automatic logic signed [CDW-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic signed [CDW-1:0] v;
        case (i)
            4'd0:    v = CDW'(64'sh20000000);
            4'd1:    v = CDW'(64'sh12E4051E);
            4'd2:    v = CDW'(64'sh09FB385B);
            4'd3:    v = CDW'(64'sh051111D4);
            4'd4:    v = CDW'(64'sh028B0D43);
            4'd5:    v = CDW'(64'sh0145D7E1);
            4'd6:    v = CDW'(64'sh00A2F61E);
            4'd7:    v = CDW'(64'sh00517C55);
            4'd8:    v = CDW'(64'sh0028BE53);
            4'd9:    v = CDW'(64'sh00145F2F);
            4'd10:   v = CDW'(64'sh000A2F98);
            4'd11:   v = CDW'(64'sh000517CC);
            4'd12:   v = CDW'(64'sh00028BE6);
            4'd13:   v = CDW'(64'sh000145F3);
            4'd14:   v = CDW'(64'sh0000A2F9);
            default: v = CDW'(64'sh0000517D);
        endcase
        return v;
    endfunction

    // angle to signed phase folded into +-quarter turn
    function automatic cordic_t prep_angle(input logic [ANGLE_WIDTH-1:0] angle);
        cordic_t               c;
        logic [31:0]           phase;
        logic signed [CDW-1:0] z;
        phase  = {angle, {(32-ANGLE_WIDTH){1'b0}}};
        z      = CDW'($signed(phase));
        c.x    = CORDIC_X0;
        c.y    = '0;
        c.flip = 1'b0;
        c.z    = z;
        if (z > QUARTER_TURN)
        begin
            c.z    = z - HALF_TURN;
            c.flip = 1'b1;
        end
        else if (z < -QUARTER_TURN)
        begin
            c.z    = z + HALF_TURN;
            c.flip = 1'b1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/evr_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// evr_cordic_cell
// One CORDIC rotation iteration for the three angles, registered, with the
// coordinates carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module evr_cordic_cell
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [evr_pkg::STEP_W-1:0] step,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire evr_pkg::cord_item_t        up_item,
    output logic                            dn_valid,
    input  wire logic                       dn_ready,
    output evr_pkg::cord_item_t             dn_item
);

    logic                valid_reg;
    evr_pkg::cord_item_t item_reg;
    evr_pkg::cord_item_t item_next;
    logic signed [evr_pkg::CDW-1:0] atan_v;

    assign atan_v = evr_pkg::atan_turn(step);

    always_comb
    begin
        item_next = up_item;
        for (int a = 0; a < 3; a++)
        begin
            if (up_item.ang[a].z >= 0)
            begin
                item_next.ang[a].x = up_item.ang[a].x - (up_item.ang[a].y >>> step);
                item_next.ang[a].y = up_item.ang[a].y + (up_item.ang[a].x >>> step);
                item_next.ang[a].z = up_item.ang[a].z - atan_v;
            end
            else
            begin
                item_next.ang[a].x = up_item.ang[a].x + (up_item.ang[a].y >>> step);
                item_next.ang[a].y = up_item.ang[a].y - (up_item.ang[a].x >>> step);
                item_next.ang[a].z = up_item.ang[a].z + atan_v;
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/evr_trig_cell.sv =====
// ----------------------------------------------------------------------------
// evr_trig_cell
// Rounds the CORDIC outputs to Q1.15, clamps and applies the half-turn sign.
// ----------------------------------------------------------------------------
`default_nettype none

module evr_trig_cell
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire evr_pkg::cord_item_t up_item,
    output logic                     dn_valid,
    input  wire logic                dn_ready,
    output evr_pkg::rot_item_t       dn_item
);

    logic               valid_reg;
    evr_pkg::rot_item_t item_reg;
    evr_pkg::rot_item_t item_next;

    function automatic logic signed [evr_pkg::TW-1:0] to_q15(
        input logic signed [evr_pkg::CDW-1:0] v,
        input logic                           flip
    );
        logic signed [evr_pkg::CDW-1:0] r;
        r = (v + evr_pkg::TRIG_HALF) >>> evr_pkg::FRAC;
        if (r > evr_pkg::TRIG_MAX)
            r = evr_pkg::TRIG_MAX;
        else if (r < evr_pkg::TRIG_MIN)
            r = evr_pkg::TRIG_MIN;
        if (flip)
            r = -r;
        return r[evr_pkg::TW-1:0];
    endfunction

    always_comb
    begin
        item_next.vec = up_item.vec;
        for (int a = 0; a < 3; a++)
        begin
            item_next.trig[a].cos_v = to_q15(up_item.ang[a].x, up_item.ang[a].flip);
            item_next.trig[a].sin_v = to_q15(up_item.ang[a].y, up_item.ang[a].flip);
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/evr_axis_cell.sv =====
// ----------------------------------------------------------------------------
// evr_axis_cell
// Rotation about one axis: a multiply stage and a sum-and-round stage.
// ----------------------------------------------------------------------------
`default_nettype none

module evr_axis_cell
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire evr_pkg::axis_t     axis,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire evr_pkg::rot_item_t up_item,
    output logic                    dn_valid,
    input  wire logic               dn_ready,
    output evr_pkg::rot_item_t      dn_item
);

    logic signed [evr_pkg::XW-1:0] a_in;
    logic signed [evr_pkg::XW-1:0] b_in;
    evr_pkg::trig_t                t_in;
    evr_pkg::prod_t                prod_next;

    logic               mul_valid_reg;
    evr_pkg::rot_item_t mul_item_reg;
    evr_pkg::prod_t     prod_reg;
    logic               mul_ready;

    logic signed [evr_pkg::SW-1:0] sum_a;
    logic signed [evr_pkg::SW-1:0] sum_b;
    logic signed [evr_pkg::SW-1:0] rnd_a;
    logic signed [evr_pkg::SW-1:0] rnd_b;
    evr_pkg::rot_item_t            item_next;

    logic               valid_reg;
    evr_pkg::rot_item_t item_reg;

    always_comb
    begin
        unique case (axis)
            evr_pkg::AXIS_ROLL:
            begin
                a_in = up_item.vec.y;
                b_in = up_item.vec.z;
                t_in = up_item.trig[0];
            end
            evr_pkg::AXIS_PITCH:
            begin
                a_in = up_item.vec.x;
                b_in = up_item.vec.z;
                t_in = up_item.trig[1];
            end
            default:
            begin
                a_in = up_item.vec.x;
                b_in = up_item.vec.y;
                t_in = up_item.trig[2];
            end
        endcase
    end

    always_comb
    begin
        prod_next.ca = evr_pkg::PW'(t_in.cos_v * a_in);
        prod_next.sb = evr_pkg::PW'(t_in.sin_v * b_in);
        prod_next.sa = evr_pkg::PW'(t_in.sin_v * a_in);
        prod_next.cb = evr_pkg::PW'(t_in.cos_v * b_in);
    end

    assign mul_ready = !valid_reg || dn_ready;
    assign up_ready  = !mul_valid_reg || mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (up_ready)
                mul_valid_reg <= up_valid;
            if (mul_ready)
                valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            mul_item_reg <= up_item;
            prod_reg     <= prod_next;
        end
    end

    always_comb
    begin
        sum_a = evr_pkg::SW'(prod_reg.ca) - evr_pkg::SW'(prod_reg.sb);
        sum_b = evr_pkg::SW'(prod_reg.sa) + evr_pkg::SW'(prod_reg.cb);
        rnd_a = (sum_a + evr_pkg::SUM_HALF) >>> evr_pkg::FRAC;
        rnd_b = (sum_b + evr_pkg::SUM_HALF) >>> evr_pkg::FRAC;
        item_next = mul_item_reg;
        unique case (axis)
            evr_pkg::AXIS_ROLL:
            begin
                item_next.vec.y = rnd_a[evr_pkg::XW-1:0];
                item_next.vec.z = rnd_b[evr_pkg::XW-1:0];
            end
            evr_pkg::AXIS_PITCH:
            begin
                item_next.vec.x = rnd_a[evr_pkg::XW-1:0];
                item_next.vec.z = rnd_b[evr_pkg::XW-1:0];
            end
            default:
            begin
                item_next.vec.x = rnd_a[evr_pkg::XW-1:0];
                item_next.vec.y = rnd_b[evr_pkg::XW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && mul_valid_reg)
            item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/euler_vector_rotate_core.sv =====
// ----------------------------------------------------------------------------
// euler_vector_rotate_core
// Rotates a Q4.12 vector about x by roll, y by pitch, then z by yaw.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready carry one request of vec_x, vec_y, vec_z
// and the three angles (unsigned fractions of a full turn).
// Output channel: out_valid / out_ready carry rot_x, rot_y, rot_z, saturated
// to the coordinate range.
// Pipeline: 16 CORDIC cells run the three sine/cosine pairs side by side, one
// rounding cell, then three axis cells of two stages each (multiply, then sum
// and round).
// Throughput: one request per cycle while out_ready is high; every cell is
// registered and passes its contents on whenever its downstream side is ready.
// Each cell has its own valid bit; a stalled receiver holds the last cell and
// bubbles further up are still filled, so in_ready stays high until every
// cell holds a request.
// Reset clears all valid bits; the pipeline comes up empty with in_ready high.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_vector_rotate_core
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [evr_pkg::COORD_WIDTH-1:0] vec_x,
    input  wire logic signed [evr_pkg::COORD_WIDTH-1:0] vec_y,
    input  wire logic signed [evr_pkg::COORD_WIDTH-1:0] vec_z,
    input  wire logic        [evr_pkg::ANGLE_WIDTH-1:0] roll_angle,
    input  wire logic        [evr_pkg::ANGLE_WIDTH-1:0] pitch_angle,
    input  wire logic        [evr_pkg::ANGLE_WIDTH-1:0] yaw_angle,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [evr_pkg::COORD_WIDTH-1:0]      rot_x,
    output logic signed [evr_pkg::COORD_WIDTH-1:0]      rot_y,
    output logic signed [evr_pkg::COORD_WIDTH-1:0]      rot_z
);

    evr_pkg::cord_item_t cord_item [evr_pkg::STEPS+1];
    logic                cord_valid [evr_pkg::STEPS+1];
    logic                cord_ready [evr_pkg::STEPS+1];

    evr_pkg::rot_item_t  rot_item  [4];
    logic                rot_valid [4];
    logic                rot_ready [4];

    always_comb
    begin
        cord_item[0].vec.x  = evr_pkg::XW'(vec_x);
        cord_item[0].vec.y  = evr_pkg::XW'(vec_y);
        cord_item[0].vec.z  = evr_pkg::XW'(vec_z);
        cord_item[0].ang[0] = evr_pkg::prep_angle(roll_angle);
        cord_item[0].ang[1] = evr_pkg::prep_angle(pitch_angle);
        cord_item[0].ang[2] = evr_pkg::prep_angle(yaw_angle);
    end

    assign cord_valid[0] = in_valid;
    assign in_ready      = cord_ready[0];

    for (genvar i = 0; i < evr_pkg::STEPS; i++)
    begin : g_cordic
        evr_cordic_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (evr_pkg::STEP_W'(i)),
            .up_valid (cord_valid[i]),
            .up_ready (cord_ready[i]),
            .up_item  (cord_item[i]),
            .dn_valid (cord_valid[i+1]),
            .dn_ready (cord_ready[i+1]),
            .dn_item  (cord_item[i+1])
        );
    end

    evr_trig_cell u_trig
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cord_valid[evr_pkg::STEPS]),
        .up_ready (cord_ready[evr_pkg::STEPS]),
        .up_item  (cord_item[evr_pkg::STEPS]),
        .dn_valid (rot_valid[0]),
        .dn_ready (rot_ready[0]),
        .dn_item  (rot_item[0])
    );

    evr_axis_cell u_roll
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .axis     (evr_pkg::AXIS_ROLL),
        .up_valid (rot_valid[0]),
        .up_ready (rot_ready[0]),
        .up_item  (rot_item[0]),
        .dn_valid (rot_valid[1]),
        .dn_ready (rot_ready[1]),
        .dn_item  (rot_item[1])
    );

    evr_axis_cell u_pitch
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .axis     (evr_pkg::AXIS_PITCH),
        .up_valid (rot_valid[1]),
        .up_ready (rot_ready[1]),
        .up_item  (rot_item[1]),
        .dn_valid (rot_valid[2]),
        .dn_ready (rot_ready[2]),
        .dn_item  (rot_item[2])
    );

    evr_axis_cell u_yaw
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .axis     (evr_pkg::AXIS_YAW),
        .up_valid (rot_valid[2]),
        .up_ready (rot_ready[2]),
        .up_item  (rot_item[2]),
        .dn_valid (rot_valid[3]),
        .dn_ready (rot_ready[3]),
        .dn_item  (rot_item[3])
    );

    function automatic logic signed [evr_pkg::COORD_WIDTH-1:0] sat(
        input logic signed [evr_pkg::XW-1:0] v
    );
        logic signed [evr_pkg::XW-1:0] r;
        r = v;
        if (v > evr_pkg::COORD_MAX)
            r = evr_pkg::COORD_MAX;
        else if (v < evr_pkg::COORD_MIN)
            r = evr_pkg::COORD_MIN;
        return r[evr_pkg::COORD_WIDTH-1:0];
    endfunction

    assign out_valid    = rot_valid[3];
    assign rot_ready[3] = out_ready;
    assign rot_x        = sat(rot_item[3].vec.x);
    assign rot_y        = sat(rot_item[3].vec.y);
    assign rot_z        = sat(rot_item[3].vec.z);

endmodule

`default_nettype wire

// ===== hdl/evr_checker.sv =====
// ----------------------------------------------------------------------------
// evr_checker
// Port-level checks of the rotation core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module evr_checker
(
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   in_ready,
    input wire logic                                   out_valid,
    input wire logic                                   out_ready,
    input wire logic signed [evr_pkg::COORD_WIDTH-1:0] rot_x,
    input wire logic signed [evr_pkg::COORD_WIDTH-1:0] rot_y,
    input wire logic signed [evr_pkg::COORD_WIDTH-1:0] rot_z
);

    // an empty output cell means every cell can take a request
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with output empty");

    a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while sink ready");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z))
        else $error("result changed while stalled");

endmodule

bind euler_vector_rotate_core evr_checker u_evr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z)
);

`default_nettype wire
